@@ src/delta_timer_queue_unit_assert.svh @@
// Assertion macros shared by the checker of the delta timer queue.
`ifndef DELTA_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DELTA_TIMER_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DTQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/dtq_pkg.sv @@
// Types, codes and constants shared by the delta timer queue files.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

   // Default pool size and the most expiries reported for one tick.
   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_OUT       = 16;
   localparam int MAX_OUT_W     = $clog2(MAX_OUT + 1);

   // Field widths of the channels.
   localparam int DELTA_W  = 32;
   localparam int OWNER_W  = 8;
   localparam int SIG_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int ERR_W    = 32;

   // Request function codes.
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_SET  = 1'b1;

   // Result kind codes.
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   // Set request status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_DUP  = 2'd2
   } status_type;

   // Control states of the queue.
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_RESP,
      S_DEC,
      S_COUNT,
      S_EMIT
   } state_type;

   // What a cell loads at the next clock edge.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_DEC,
      OP_TAKE_RIGHT,
      OP_TAKE_LEFT,
      OP_TAKE_LEFT_ADJ,
      OP_LOAD_NEW
   } cell_op_type;

   // One timer entry of the delta list.
   typedef struct packed {
      logic [DELTA_W-1:0] delta;
      logic [OWNER_W-1:0] owner;
      logic [SIG_W-1:0]   signals;
   } entry_type;

endpackage

`default_nettype wire

@@ src/dtq_if.sv @@
// Valid/ready channel interfaces for the requests and results of the timer queue.
`timescale 1ns / 1ps
`default_nettype none

interface dtq_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [dtq_pkg::OWNER_W-1:0]  owner;
   logic [dtq_pkg::DELTA_W-1:0]  duration;
   logic [dtq_pkg::SIG_W-1:0]    signal_mask;

   modport source (output valid, func, owner, duration, signal_mask, input ready);
   modport sink   (input valid, func, owner, duration, signal_mask, output ready);
endinterface

interface dtq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [dtq_pkg::STATUS_W-1:0] status;
   logic [dtq_pkg::OWNER_W-1:0]  expired_owner;
   logic [dtq_pkg::SIG_W-1:0]    expired_signals;
   logic                         last;
   logic [dtq_pkg::COUNT_W-1:0]  active_count;
   logic [dtq_pkg::ERR_W-1:0]    error_total;

   modport source (output valid, kind, status, expired_owner, expired_signals, last,
                   active_count, error_total, input ready);
   modport sink   (input valid, kind, status, expired_owner, expired_signals, last,
                   active_count, error_total, output ready);
endinterface

`default_nettype wire

@@ src/delta_timer_queue_unit.sv @@
// Top level of the delta timer queue: control sequencer around a row of list cells.
//
// The req_ch channel takes one item at a time, either a timer tick or a set
// request (owner, duration, signal mask). The rsp_ch channel returns results.
// A set request gives exactly one status item. A tick gives one expiry item
// for each timer that runs out, the final one flagged by last, or nothing.
// Every result carries the active timer count after the whole step and the
// saturating count of duplicate-owner rejections.
// Sequence: a rejected set passes the check state and then waits in the result
// state for rsp_ch.ready; an accepted set walks the cells between the check and
// the result, since the insert point is found by a walk over the cells at one
// compare and subtract per cycle. A tick decrements the head, counts the due run
// and then emits its expiry items; a tick on an empty list gives no result.
// A new item is accepted only once all results of the previous one are taken.
// While rsp_ch.ready is low the pending result holds and the list is frozen.
// Reset clears the sequencer, the active count and the error count; entry
// contents need no clearing since only the first active_count cells are read.
`timescale 1ns / 1ps
`default_nettype none

module delta_timer_queue_unit #(
   parameter int SLOTS = dtq_pkg::SLOTS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   dtq_req_if.sink     req_ch,
   dtq_rsp_if.source   rsp_ch
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int RW = dtq_pkg::MAX_OUT_W;

   dtq_pkg::state_type  state_ff, state_in;
   dtq_pkg::status_type status_ff, status_in;
   logic [CW-1:0]                 active_ff, active_in;
   logic [dtq_pkg::ERR_W-1:0]     err_ff, err_in;
   logic [dtq_pkg::DELTA_W-1:0]   rem_ff, rem_in;
   logic [IW-1:0]                 pos_ff, pos_in;
   logic [dtq_pkg::OWNER_W-1:0]   owner_ff, owner_in;
   logic [dtq_pkg::SIG_W-1:0]     sig_ff, sig_in;
   logic [RW-1:0]                 left_ff, left_in;

   dtq_pkg::entry_type    fresh;
   dtq_pkg::entry_type    entries [SLOTS];
   dtq_pkg::cell_op_type  cell_op [SLOTS];
   logic [SLOTS:0]        zrun;
   logic [SLOTS-1:0]      hits;

   logic          req_take;
   logic          full;
   logic          dup;
   logic          pos_live;
   logic          advance;
   logic          insert_go;
   logic [CW-1:0] n_raw;
   logic [RW-1:0] n_sel;

   // New entry as it travels down the list during a set.
   assign fresh.delta   = rem_ff;
   assign fresh.owner   = owner_ff;
   assign fresh.signals = sig_ff;

   assign zrun[0] = 1'b1;

   // Row of cells, each with its own load command.
   for (genvar g = 0; g < SLOTS; g++) begin : g_row
      localparam logic [CW-1:0] CellIdx = CW'(g);

      dtq_pkg::entry_type left_nb;
      dtq_pkg::entry_type right_nb;
      logic [CW-1:0]      pos_ext;

      if (g == 0) begin : g_first
         assign left_nb = fresh;
      end else begin : g_inner_left
         assign left_nb = entries[g-1];
      end

      if (g == SLOTS - 1) begin : g_final
         assign right_nb = fresh;
      end else begin : g_inner_right
         assign right_nb = entries[g+1];
      end

      assign pos_ext = CW'(pos_ff);

      // Command for this cell from the sequencer state.
      always_comb begin
         cell_op[g] = dtq_pkg::OP_HOLD;
         case (state_ff)
            dtq_pkg::S_DEC: begin
               if (CellIdx == '0) begin
                  cell_op[g] = dtq_pkg::OP_DEC;
               end
            end
            dtq_pkg::S_EMIT: begin
               if (rsp_ch.ready) begin
                  cell_op[g] = dtq_pkg::OP_TAKE_RIGHT;
               end
            end
            dtq_pkg::S_WALK: begin
               if (insert_go) begin
                  if (CellIdx == pos_ext) begin
                     cell_op[g] = dtq_pkg::OP_LOAD_NEW;
                  end else if (CellIdx == pos_ext + 1'b1) begin
                     cell_op[g] = dtq_pkg::OP_TAKE_LEFT_ADJ;
                  end else if (CellIdx > pos_ext + 1'b1) begin
                     cell_op[g] = dtq_pkg::OP_TAKE_LEFT;
                  end
               end
            end
            default: begin
               cell_op[g] = dtq_pkg::OP_HOLD;
            end
         endcase
      end

      dtq_cell u_cell (
         .clock    (clock),
         .op       (cell_op[g]),
         .left     (left_nb),
         .right    (right_nb),
         .fresh    (fresh),
         .live     (CellIdx < active_ff),
         .zrun_in  (zrun[g]),
         .zrun_out (zrun[g+1]),
         .hit      (hits[g]),
         .entry    (entries[g])
      );
   end

   // Request handshake and set checks.
   assign req_take  = req_ch.valid && req_ch.ready;
   assign full      = (active_ff == CW'(SLOTS));
   assign dup       = |hits;
   assign pos_live  = (CW'(pos_ff) < active_ff);
   assign advance   = pos_live && (entries[pos_ff].delta < rem_ff);
   assign insert_go = (state_ff == dtq_pkg::S_WALK) && !advance;

   // Length of the leading run of due entries, read off the thermometer code.
   always_comb begin
      n_raw = '0;
      for (int k = 1; k < SLOTS; k++) begin
         if (zrun[k] && !zrun[k+1]) begin
            n_raw = n_raw | CW'(k);
         end
      end
      if (zrun[SLOTS]) begin
         n_raw = n_raw | CW'(SLOTS);
      end
   end

   // At most MAX_OUT expiries are reported per tick.
   assign n_sel = (32'(n_raw) > 32'(dtq_pkg::MAX_OUT)) ? RW'(dtq_pkg::MAX_OUT) : RW'(n_raw);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtq_pkg::S_IDLE: begin
            if (req_take) begin
               if (req_ch.func == dtq_pkg::FUNC_SET) begin
                  state_in = dtq_pkg::S_CHECK;
               end else if (active_ff != '0) begin
                  state_in = dtq_pkg::S_DEC;
               end
            end
         end
         dtq_pkg::S_CHECK: begin
            state_in = (full || dup) ? dtq_pkg::S_RESP : dtq_pkg::S_WALK;
         end
         dtq_pkg::S_WALK: begin
            if (!advance) begin
               state_in = dtq_pkg::S_RESP;
            end
         end
         dtq_pkg::S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = dtq_pkg::S_IDLE;
            end
         end
         dtq_pkg::S_DEC: begin
            state_in = dtq_pkg::S_COUNT;
         end
         dtq_pkg::S_COUNT: begin
            state_in = (n_sel == '0) ? dtq_pkg::S_IDLE : dtq_pkg::S_EMIT;
         end
         dtq_pkg::S_EMIT: begin
            if (rsp_ch.ready && (left_ff == RW'(1))) begin
               state_in = dtq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dtq_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath registers of the sequencer.
   always_comb begin
      status_in = status_ff;
      active_in = active_ff;
      err_in    = err_ff;
      rem_in    = rem_ff;
      pos_in    = pos_ff;
      owner_in  = owner_ff;
      sig_in    = sig_ff;
      left_in   = left_ff;
      case (state_ff)
         dtq_pkg::S_IDLE: begin
            if (req_take && (req_ch.func == dtq_pkg::FUNC_SET)) begin
               owner_in = req_ch.owner;
               sig_in   = req_ch.signal_mask;
               rem_in   = (req_ch.duration == '0) ? dtq_pkg::DELTA_W'(1) : req_ch.duration;
            end
         end
         dtq_pkg::S_CHECK: begin
            pos_in = '0;
            if (full) begin
               status_in = dtq_pkg::STATUS_FULL;
            end else if (dup) begin
               status_in = dtq_pkg::STATUS_DUP;
               if (err_ff != '1) begin
                  err_in = err_ff + 1'b1;
               end
            end else begin
               status_in = dtq_pkg::STATUS_OK;
            end
         end
         dtq_pkg::S_WALK: begin
            // Skip past entries that are due strictly earlier.
            if (advance) begin
               rem_in = rem_ff - entries[pos_ff].delta;
               pos_in = pos_ff + 1'b1;
            end else begin
               active_in = active_ff + 1'b1;
            end
         end
         dtq_pkg::S_COUNT: begin
            if (n_sel != '0) begin
               left_in   = n_sel;
               active_in = active_ff - CW'(n_sel);
            end
         end
         dtq_pkg::S_EMIT: begin
            if (rsp_ch.ready) begin
               left_in = left_ff - 1'b1;
            end
         end
         default: begin
            left_in = left_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dtq_pkg::S_IDLE;
         active_ff <= '0;
         err_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rem_ff    <= rem_in;
      pos_ff    <= pos_in;
      owner_ff  <= owner_in;
      sig_ff    <= sig_in;
      left_ff   <= left_in;
   end

   // Channel outputs from the sequencer state and the head cell.
   always_comb begin
      req_ch.ready           = (state_ff == dtq_pkg::S_IDLE);
      rsp_ch.valid           = 1'b0;
      rsp_ch.kind            = dtq_pkg::KIND_STATUS;
      rsp_ch.status          = dtq_pkg::STATUS_OK;
      rsp_ch.expired_owner   = '0;
      rsp_ch.expired_signals = '0;
      rsp_ch.last            = 1'b1;
      rsp_ch.active_count    = dtq_pkg::COUNT_W'(active_ff);
      rsp_ch.error_total     = err_ff;
      case (state_ff)
         dtq_pkg::S_RESP: begin
            rsp_ch.valid  = 1'b1;
            rsp_ch.status = status_ff;
         end
         dtq_pkg::S_EMIT: begin
            rsp_ch.valid           = 1'b1;
            rsp_ch.kind            = dtq_pkg::KIND_EXPIRY;
            rsp_ch.expired_owner   = entries[0].owner;
            rsp_ch.expired_signals = entries[0].signals;
            rsp_ch.last            = (left_ff == RW'(1));
         end
         default: begin
            rsp_ch.valid = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/dtq_cell.sv @@
// One cell of the delta list: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module dtq_cell (
   input  wire logic                 clock,
   input  var dtq_pkg::cell_op_type  op,
   input  var dtq_pkg::entry_type    left,
   input  var dtq_pkg::entry_type    right,
   input  var dtq_pkg::entry_type    fresh,
   input  wire logic                 live,
   input  wire logic                 zrun_in,
   output logic                      zrun_out,
   output logic                      hit,
   output dtq_pkg::entry_type        entry
);

   dtq_pkg::entry_type entry_ff;
   dtq_pkg::entry_type entry_in;

   // Select the next contents of the cell.
   always_comb begin
      entry_in = entry_ff;
      case (op)
         dtq_pkg::OP_HOLD: begin
            entry_in = entry_ff;
         end
         dtq_pkg::OP_DEC: begin
            if (entry_ff.delta != '0) begin
               entry_in.delta = entry_ff.delta - 1'b1;
            end
         end
         dtq_pkg::OP_TAKE_RIGHT: begin
            entry_in = right;
         end
         dtq_pkg::OP_TAKE_LEFT: begin
            entry_in = left;
         end
         dtq_pkg::OP_TAKE_LEFT_ADJ: begin
            // The entry behind a new timer now counts from the new deadline.
            entry_in       = left;
            entry_in.delta = left.delta - fresh.delta;
         end
         dtq_pkg::OP_LOAD_NEW: begin
            entry_in = fresh;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Leading run of due entries and owner match for the duplicate check.
   assign zrun_out = zrun_in & live & (entry_ff.delta == '0);
   assign hit      = live & (entry_ff.owner == fresh.owner);
   assign entry    = entry_ff;

endmodule

`default_nettype wire

@@ src/dtq_checker.sv @@
// Port-level assertions for the delta timer queue, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "delta_timer_queue_unit_assert.svh"

module dtq_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         rsp_kind,
   input wire logic [dtq_pkg::STATUS_W-1:0] rsp_status,
   input wire logic                         rsp_last
);

   // A pending result is not withdrawn before it is taken.
   `DTQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // No new item is taken while a result is still pending.
   `DTQ_ASSERT_IMPLY(a_no_overlap, clock, reset, rsp_valid, !req_ready, "item accepted during pending result")

   // Expiry events never carry a set status code.
   `DTQ_ASSERT_IMPLY(a_expiry_status, clock, reset, rsp_valid && (rsp_kind == dtq_pkg::KIND_EXPIRY), rsp_status == dtq_pkg::STATUS_OK, "expiry with nonzero status")

   // After the final result of an item is taken, the block returns to idle and offers no result.
   `DTQ_ASSERT_NEXT(a_last_idle, clock, reset, rsp_valid && rsp_ready && rsp_last, !rsp_valid, "result after last")

endmodule

bind delta_timer_queue_unit dtq_checker u_dtq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_kind   (rsp_ch.kind),
   .rsp_status (rsp_ch.status),
   .rsp_last   (rsp_ch.last)
);

`default_nettype wire

@@ test/delta_timer_queue_unit_checker.sv @@
// Checker of the delta timer queue: predicts the results of every item and compares them.
`timescale 1ns / 1ps

module delta_timer_queue_unit_checker
   import dtq_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   dtq_req_if   req_mon,
   dtq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   expected_left
);

   // One result as the block should present it.
   typedef struct packed {
      logic               kind;
      status_type         status;
      logic [OWNER_W-1:0] owner;
      logic [SIG_W-1:0]   signals;
      logic               last;
      logic [COUNT_W-1:0] count;
      logic [ERR_W-1:0]   errors;
   } outcome_type;

   // Predicted timer list: head at index 0, each delta relative to the entry before.
   logic [DELTA_W-1:0] wait_ticks [SLOTS];
   logic [OWNER_W-1:0] held_owner [SLOTS];
   logic [SIG_W-1:0]   held_sigs  [SLOTS];
   int unsigned        live;
   logic [ERR_W-1:0]   dup_errors;

   outcome_type        due_q [$];
   int                 mismatches = 0;

   assign fail_count = mismatches;

   // Print a mismatch (only the first few, to keep the log short) and count it.
   task automatic report_mismatch(input string what);
      if (mismatches < 40) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
      end
   endtask

   // A set request: reject on a full pool first, then on a duplicate owner, else insert.
   task automatic predict_set(input logic [OWNER_W-1:0] who, input logic [DELTA_W-1:0] span,
                              input logic [SIG_W-1:0] sigs);
      status_type         verdict;
      logic [DELTA_W-1:0] rem;
      int unsigned        pos;
      int unsigned        i;
      outcome_type        res;
      verdict = STATUS_OK;
      if (live >= SLOTS) begin
         verdict = STATUS_FULL;
      end else begin
         for (i = 0; i < live; i++) begin
            if (held_owner[i] == who) verdict = STATUS_DUP;
         end
      end
      if (verdict == STATUS_DUP && dup_errors != '1) dup_errors++;
      if (verdict == STATUS_OK) begin
         // Walk past entries that fall due strictly earlier, consuming their deltas.
         rem = (span == '0) ? DELTA_W'(1) : span;
         pos = 0;
         while (pos < live && wait_ticks[pos] < rem) begin
            rem -= wait_ticks[pos];
            pos++;
         end
         for (i = live; i > pos; i--) begin
            wait_ticks[i] = wait_ticks[i-1];
            held_owner[i] = held_owner[i-1];
            held_sigs[i]  = held_sigs[i-1];
         end
         wait_ticks[pos] = rem;
         held_owner[pos] = who;
         held_sigs[pos]  = sigs;
         if (pos < live) wait_ticks[pos+1] -= rem;
         live++;
      end
      res.kind    = KIND_STATUS;
      res.status  = verdict;
      res.owner   = '0;
      res.signals = '0;
      res.last    = 1'b1;
      res.count   = COUNT_W'(live);
      res.errors  = dup_errors;
      due_q.push_back(res);
   endtask

   // A tick: decrement the head, then retire the leading entries at zero, at most MAX_OUT of them.
   task automatic predict_tick();
      logic [OWNER_W-1:0] gone_owner [MAX_OUT];
      logic [SIG_W-1:0]   gone_sigs  [MAX_OUT];
      int unsigned        n;
      int unsigned        i;
      outcome_type        res;
      if (live == 0) return;
      if (wait_ticks[0] != '0) wait_ticks[0]--;
      n = 0;
      while (live > 0 && wait_ticks[0] == '0 && n < MAX_OUT) begin
         gone_owner[n] = held_owner[0];
         gone_sigs[n]  = held_sigs[0];
         n++;
         for (i = 1; i < live; i++) begin
            wait_ticks[i-1] = wait_ticks[i];
            held_owner[i-1] = held_owner[i];
            held_sigs[i-1]  = held_sigs[i];
         end
         live--;
      end
      // The count carried by each expiry is the one after the whole tick.
      for (i = 0; i < n; i++) begin
         res.kind    = KIND_EXPIRY;
         res.status  = STATUS_OK;
         res.owner   = gone_owner[i];
         res.signals = gone_sigs[i];
         res.last    = (i == n - 1);
         res.count   = COUNT_W'(live);
         res.errors  = dup_errors;
         due_q.push_back(res);
      end
   endtask

   // Compare one accepted result with the oldest prediction.
   task automatic check_result();
      outcome_type want;
      if (due_q.size() == 0) begin
         report_mismatch($sformatf("result kind %0d owner %0d arrived with none predicted",
                                   rsp_mon.kind, rsp_mon.expired_owner));
         return;
      end
      want = due_q.pop_front();
      compare_field("kind",            32'(rsp_mon.kind),            32'(want.kind));
      compare_field("status",          32'(rsp_mon.status),          32'(want.status));
      compare_field("expired_owner",   32'(rsp_mon.expired_owner),   32'(want.owner));
      compare_field("expired_signals", 32'(rsp_mon.expired_signals), 32'(want.signals));
      compare_field("last",            32'(rsp_mon.last),            32'(want.last));
      compare_field("active_count",    32'(rsp_mon.active_count),    32'(want.count));
      compare_field("error_total",     32'(rsp_mon.error_total),     32'(want.errors));
   endtask

   // Both channels are sampled at the rising edge; results are checked before new predictions.
   always @(posedge clock) begin
      if (reset) begin
         live       = 0;
         dup_errors = '0;
         due_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_SET) begin
               predict_set(req_mon.owner, req_mon.duration, req_mon.signal_mask);
            end else begin
               predict_tick();
            end
         end
      end
      expected_left <= due_q.size();
   end

endmodule

@@ test/delta_timer_queue_unit_tb.sv @@
// Testbench top of the delta timer queue: clock, reset, stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps

module delta_timer_queue_unit_tb;
   import dtq_pkg::*;

   localparam int SLOTS         = SLOTS_DEFAULT;
   localparam int ITEM_GOAL     = 350;
   localparam int HOLD_AT       = 110;
   localparam int HOLD_CYCLES   = 300;
   localparam int CALM_FROM     = 150;
   localparam int CALM_TO       = 230;
   localparam int DRAIN_AT      = 260;
   localparam int SETTLE_CYCLES = 40;

   logic clock;
   logic reset;
   int   fail_count;
   int   expected_left;
   int   sent         = 0;
   int   holds_asked  = 0;
   int   holds_served = 0;
   int   hold_left    = 0;
   logic calm         = 1'b0;

   dtq_req_if req_ch ();
   dtq_rsp_if rsp_ch ();

   delta_timer_queue_unit #(
      .SLOTS (SLOTS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   delta_timer_queue_unit_checker #(
      .SLOTS (SLOTS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   // 50 MHz clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Result side: random stalls, none in the calm stretch, and one long hold when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_ch.ready <= 1'b0;
         holds_served <= holds_asked;
         hold_left    <= HOLD_CYCLES;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   // Offer one item and wait until it is taken; then maybe idle, hold the receiver or drain.
   task automatic send_item(input logic op, input logic [OWNER_W-1:0] who,
                            input logic [DELTA_W-1:0] span, input logic [SIG_W-1:0] sigs);
      req_ch.valid       <= 1'b1;
      req_ch.func        <= op;
      req_ch.owner       <= who;
      req_ch.duration    <= span;
      req_ch.signal_mask <= sigs;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sent++;
      calm <= (sent >= CALM_FROM && sent < CALM_TO);
      if (sent == HOLD_AT) holds_asked <= holds_asked + 1;
      if (sent == DRAIN_AT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (expected_left != 0) @(posedge clock);
      end else if (!calm && $urandom_range(99) < 13) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Tick items carry random payload, which the block must ignore.
   task automatic tick();
      send_item(FUNC_TICK, OWNER_W'($urandom), DELTA_W'($urandom), SIG_W'($urandom));
   endtask

   task automatic set_timer(input logic [OWNER_W-1:0] who, input logic [DELTA_W-1:0] span,
                            input logic [SIG_W-1:0] sigs);
      send_item(FUNC_SET, who, span, sigs);
   endtask

   // Run-time limit.
   initial begin
      #10_000_000;
      $display("delta_timer_queue_unit regression: fail");
      $finish;
   end

   // Reset, directed items, random items, then the verdict.
   initial begin
      int                 k;
      int                 base;
      int                 burst;
      int                 pick;
      logic [OWNER_W-1:0] who;
      logic [DELTA_W-1:0] span;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_TICK;
      req_ch.owner       = '0;
      req_ch.duration    = '0;
      req_ch.signal_mask = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // A tick on an empty list gives nothing.
      tick();
      // Fill the pool with timers all due on the next tick; a zero duration counts as one,
      // and equal deadlines go in front, so they expire newest first.
      for (k = 0; k < SLOTS; k++) begin
         set_timer(OWNER_W'(k), (k == 0) ? '0 : DELTA_W'(1), SIG_W'($urandom));
      end
      // Pool full, and pool full with a duplicate owner (full takes precedence).
      set_timer(OWNER_W'(200), DELTA_W'(1), SIG_W'($urandom));
      set_timer(OWNER_W'(3), DELTA_W'(1), SIG_W'($urandom));
      // All sixteen expire on one tick.
      tick();
      // Largest duration and mask, then a duplicate owner.
      set_timer('1, '1, '1);
      set_timer('1, '0, '0);
      // A shorter timer goes in front; the first tick retires nothing.
      set_timer(OWNER_W'(7), DELTA_W'(3), SIG_W'($urandom));
      set_timer(OWNER_W'(8), DELTA_W'(2), SIG_W'($urandom));
      tick();
      tick();

      // Random part: mostly mixed traffic over a small owner set, with bursts of
      // timers that all fall due together.
      while (sent < ITEM_GOAL) begin
         if ($urandom_range(9) < 2) begin
            base  = $urandom_range(32, 230);
            span  = DELTA_W'($urandom_range(1, 3));
            burst = $urandom_range(8, SLOTS);
            for (k = 0; k < burst; k++) begin
               set_timer(OWNER_W'(base + k), span, SIG_W'($urandom));
            end
            repeat (int'(span) + 1) tick();
         end else begin
            for (k = 0; k < 20; k++) begin
               if ($urandom_range(99) < 45) begin
                  who  = ($urandom_range(3) != 0) ? OWNER_W'($urandom_range(24))
                                                  : OWNER_W'($urandom);
                  pick = $urandom_range(99);
                  if (pick < 8) begin
                     span = '0;
                  end else if (pick < 80) begin
                     span = DELTA_W'($urandom_range(1, 6));
                  end else begin
                     span = DELTA_W'($urandom_range(7, 48));
                  end
                  set_timer(who, span, SIG_W'($urandom));
               end else begin
                  tick();
               end
            end
         end
      end

      // Let every predicted result arrive, then give a tick in flight time to finish.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_left == 0) begin
         $display("delta_timer_queue_unit regression: pass");
      end else begin
         $display("delta_timer_queue_unit regression: fail");
      end
      $finish;
   end

endmodule
